>>> rtl/isl_pkg.sv
// Shared types for the indexed shift list: command codes, status codes
// and the control word broadcast to every storage cell. No dependencies.
package isl_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_APPEND = 2'd2,
      OP_POP    = 2'd3
   } isl_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } isl_status_type;

   // Control broadcast along the cell row for one accepted command.
   typedef struct packed {
      logic ins;   // open a slot at the position and load the new word
      logic rem;   // close the slot at the position
   } isl_ctl_type;

endpackage

>>> rtl/isl_if.sv
// Valid/ready channel interfaces for the command and result streams.
// Standalone; widths come from the instantiating scope.
interface isl_req_if #(
   parameter int IDX_W  = 5,
   parameter int WORD_W = 32
) ();
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [IDX_W-1:0]  position;
   logic [WORD_W-1:0] word_in;

   modport source (output valid, op, position, word_in, input ready);
   modport sink   (input valid, op, position, word_in, output ready);
endinterface

interface isl_rsp_if #(
   parameter int IDX_W  = 5,
   parameter int WORD_W = 32
) ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word_out;
   logic [1:0]        status;
   logic [IDX_W-1:0]  count_out;

   modport source (output valid, word_out, status, count_out, input ready);
   modport sink   (input valid, word_out, status, count_out, output ready);
endinterface

>>> rtl/isl_cell.sv
// One list slot: holds a word and takes from its lower or upper neighbor
// when a command opens or closes a slot at or below it. Uses isl_pkg.
module isl_cell #(
   parameter int IDX_W  = 5,
   parameter int WORD_W = 32,
   parameter int INDEX  = 0
) (
   input  logic                 clock,
   input  isl_pkg::isl_ctl_type ctl,
   input  logic [IDX_W-1:0]     pos,
   input  logic [WORD_W-1:0]    new_word,
   input  logic [WORD_W-1:0]    from_below,
   input  logic [WORD_W-1:0]    from_above,
   output logic [WORD_W-1:0]    data_out,
   output logic [WORD_W-1:0]    tap_out
);
   import isl_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;
   logic              at_pos;
   logic              above_pos;

   assign at_pos    = (pos == MY_IDX);
   assign above_pos = (pos < MY_IDX);

   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (at_pos) begin
            data_in = new_word;
         end else if (above_pos) begin
            data_in = from_below;
         end
      end else if (ctl.rem) begin
         // close the gap: everything at or above the slot moves down
         if (at_pos || above_pos) begin
            data_in = from_above;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign tap_out  = at_pos ? data_ff : '0;

endmodule

>>> rtl/indexed_shift_list.sv
// Indexed shift list top level: command decode, length register, result
// register and the row of isl_cell slots. Uses isl_pkg and isl_if.
//
// Usage:
//   req_ch carries one command per transfer: op (insert at index, remove
//   at index, append, pop), position and word_in. rsp_ch returns exactly
//   one result per command: the removed word (zero unless a remove or pop
//   succeeds), a status code and the list length after the command.
//   Every slot updates in parallel in the cycle a command is taken, so
//   one command is taken per cycle while no result is stalled, and the
//   result appears on rsp_ch in the cycle after the request transfer. The
//   decode, the status checks and the removed-word select (an OR over the
//   per-slot taps) sit between the length register and the result
//   register.
//   A rejected command (full, index out of range, empty) leaves the list
//   untouched.
//   Reset empties the list and drops any pending result; slot contents
//   are not cleared, since only slots below the length are ever read.
//   While a result waits with rsp_ch.ready low, req_ch.ready stays low; a
//   new command is taken in the same cycle the waiting result transfers.
module indexed_shift_list #(
   parameter int CAPACITY   = 16,
   parameter int WORD_WIDTH = 32
) (
   input logic     clock,
   input logic     reset,
   isl_req_if.sink   req_ch,
   isl_rsp_if.source rsp_ch
);
   import isl_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] CAP_CNT = IDX_W'(CAPACITY);

   logic [IDX_W-1:0]      count_ff;
   logic [IDX_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [WORD_WIDTH-1:0] word_out_ff;
   logic [WORD_WIDTH-1:0] word_out_in;
   isl_status_type        status_ff;
   isl_status_type        status_in;

   isl_op_type            op;
   logic                  fire;
   logic                  is_add;
   logic [IDX_W-1:0]      eff_pos;
   isl_ctl_type           ctl;
   logic [WORD_WIDTH-1:0] removed;

   logic [WORD_WIDTH-1:0] cell_data [CAPACITY];
   logic [WORD_WIDTH-1:0] cell_tap  [CAPACITY];

   assign op     = isl_op_type'(req_ch.op);
   assign is_add = (op == OP_INSERT) || (op == OP_APPEND);
   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign fire   = req_ch.valid && req_ch.ready;

   always_comb begin
      case (op)
         OP_INSERT: eff_pos = req_ch.position;
         OP_REMOVE: eff_pos = req_ch.position;
         OP_APPEND: eff_pos = count_ff;
         OP_POP:    eff_pos = count_ff - IDX_W'(1);
         default:   eff_pos = req_ch.position;
      endcase
   end

   // Fullness and emptiness are checked before the index.
   always_comb begin
      status_in = ST_OK;
      if (is_add) begin
         if (count_ff == CAP_CNT) begin
            status_in = ST_FULL;
         end else if (eff_pos > count_ff) begin
            status_in = ST_RANGE;
         end
      end else begin
         if (count_ff == '0) begin
            status_in = ST_EMPTY;
         end else if (eff_pos >= count_ff) begin
            status_in = ST_RANGE;
         end
      end
   end

   assign ctl.ins = fire && (status_in == ST_OK) && is_add;
   assign ctl.rem = fire && (status_in == ST_OK) && !is_add;

   always_comb begin
      removed = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         removed = removed | cell_tap[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + IDX_W'(1);
      end else if (ctl.rem) begin
         count_in = count_ff - IDX_W'(1);
      end
   end

   assign word_out_in  = ctl.rem ? removed : '0;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result until it transfers
   always_ff @(posedge clock) begin
      if (fire) begin
         word_out_ff <= word_out_in;
         status_ff   <= status_in;
      end
   end

   generate
      for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
         logic [WORD_WIDTH-1:0] below_word;
         logic [WORD_WIDTH-1:0] above_word;

         if (g == 0) begin : g_first
            assign below_word = req_ch.word_in;
         end else begin : g_mid_lo
            assign below_word = cell_data[g-1];
         end

         if (g == CAPACITY - 1) begin : g_last
            assign above_word = cell_data[g];
         end else begin : g_mid_hi
            assign above_word = cell_data[g+1];
         end

         isl_cell #(
            .IDX_W  (IDX_W),
            .WORD_W (WORD_WIDTH),
            .INDEX  (g)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .pos        (eff_pos),
            .new_word   (req_ch.word_in),
            .from_below (below_word),
            .from_above (above_word),
            .data_out   (cell_data[g]),
            .tap_out    (cell_tap[g])
         );
      end
   endgenerate

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.word_out  = word_out_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.count_out = count_ff;

endmodule

>>> rtl/isl_check.sv
// Port-level checks for indexed_shift_list, attached by bind.
// Uses isl_pkg status codes.
module isl_check #(
   parameter int IDX_W    = 5,
   parameter int WORD_W   = 32,
   parameter int CAPACITY = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] word_out,
   input logic [1:0]        status,
   input logic [IDX_W-1:0]  count_out
);
   import isl_pkg::*;

   localparam logic [IDX_W-1:0] CAP_CNT = IDX_W'(CAPACITY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(word_out)
         && $stable(status) && $stable(count_out))
      else $error("stalled result changed");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result one cycle after command transfer");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("command stalled with empty result register");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_out <= CAP_CNT)
      else $error("length above capacity");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_OK |-> word_out == '0)
      else $error("rejected command returned a word");

endmodule

bind indexed_shift_list isl_check #(
   .IDX_W    (IDX_W),
   .WORD_W   (WORD_WIDTH),
   .CAPACITY (CAPACITY)
) u_isl_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .word_out  (rsp_ch.word_out),
   .status    (rsp_ch.status),
   .count_out (rsp_ch.count_out)
);
